[rtl/core/ook_pwd_pkg.sv]
package ook_pwd_pkg;

  localparam int DUR_W      = 20;
  localparam int TOL_W      = 7;
  localparam int CODE_W     = 32;
  localparam int BITS_W     = 6;
  localparam int UNIT_OUT_W = 15;
  localparam int IDX_W      = 8;
  localparam int PCT_DIV    = 100;

  localparam logic [TOL_W-1:0] TOL_RESET = 7'd60;
  localparam logic [IDX_W-1:0] IDX_MAX   = 8'd255;
  localparam logic [IDX_W-1:0] FIRST_POS = 8'd3;
  localparam logic [IDX_W-1:0] LAST_POS  = 8'd254;
  localparam logic [IDX_W-1:0] STORE_MIN = 8'd6;

  localparam int CLS_SHORT = 0;
  localparam int CLS_LONG  = 1;

  localparam logic [1:0] SLOT_CHECK = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             frame_start;
    logic             frame_end;
  } ook_pwd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]     code;
    logic [BITS_W-1:0]     bit_count;
    logic [UNIT_OUT_W-1:0] unit_delay;
    logic                  stored;
    logic                  decoded;
  } ook_pwd_out_t;

  typedef enum logic [1:0] {
    KIND_SYNC,
    KIND_SKIP,
    KIND_SLOT,
    KIND_CHECK
  } ook_pwd_kind_t;

  typedef struct packed {
    logic [DUR_W-1:0]  duration;
    ook_pwd_kind_t     kind;
    logic [1:0]        slot;
    logic              last;
    logic [BITS_W-1:0] bit_count;
    logic              stored;
  } ook_pwd_entry_t;

  typedef struct packed {
    logic           valid;
    ook_pwd_entry_t entry;
  } ook_pwd_head_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_UNIT,
    BK_WIN
  } ook_pwd_bstate_t;

endpackage

[rtl/core/ook_pwd_front.sv]
module ook_pwd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ook_pwd_pkg::ook_pwd_in_t    in_data,
  input  logic                        q_full,
  output logic                        push,
  output ook_pwd_pkg::ook_pwd_entry_t push_entry
);
  import ook_pwd_pkg::*;

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W-1:0] off;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    pos     = in_data.frame_start ? '0 : idx_r;
    pos_inc = (pos == IDX_MAX) ? pos : pos + 1'b1;
    off     = pos - FIRST_POS;

    push_entry.duration  = in_data.duration;
    push_entry.slot      = off[1:0];
    push_entry.last      = in_data.frame_end;
    push_entry.bit_count = pos_inc[IDX_W-1:2];
    push_entry.stored    = pos_inc > STORE_MIN;

    if (pos == '0) begin
      push_entry.kind = KIND_SYNC;
    end else if (pos inside {[FIRST_POS:LAST_POS]}) begin
      push_entry.kind = (off[1:0] == SLOT_CHECK) ? KIND_CHECK : KIND_SLOT;
    end else begin
      push_entry.kind = KIND_SKIP;
    end

    idx_nxt = idx_r;
    if (push) begin
      idx_nxt = in_data.frame_end ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[rtl/core/ook_pwd_fifo.sv]
module ook_pwd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  ook_pwd_pkg::ook_pwd_entry_t push_entry,
  output logic                        full,
  output ook_pwd_pkg::ook_pwd_head_t  head,
  input  logic                        pop
);
  import ook_pwd_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ook_pwd_entry_t   mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == CNT_W'(DEPTH));
  assign head = {(count_r != '0), mem_r[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/core/ook_pwd_back.sv]
module ook_pwd_back #(
  parameter int CODE_BITS  = 32,
  parameter int SYNC_RATIO = 38,
  parameter int LONG_RATIO = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ook_pwd_pkg::TOL_W-1:0]     tolerance,
  input  ook_pwd_pkg::ook_pwd_head_t        head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ook_pwd_pkg::ook_pwd_out_t         out_data
);
  import ook_pwd_pkg::*;

  localparam int UNIT_W = $clog2(((1 << DUR_W) - 1) / SYNC_RATIO + 1);
  localparam int M1_SH  = DUR_W + 8;
  localparam int M1_W   = M1_SH + 1;
  localparam logic [M1_W-1:0] M1 =
    M1_W'(((longint'(1) << M1_SH) + SYNC_RATIO - 1) / SYNC_RATIO);
  localparam int P1_W   = DUR_W + M1_W;
  localparam int WP_W   = UNIT_W + TOL_W;
  localparam int M2_SH  = WP_W + 7;
  localparam int M2_W   = M2_SH - 6;
  localparam logic [M2_W-1:0] M2 =
    M2_W'(((longint'(1) << M2_SH) + PCT_DIV - 1) / PCT_DIV);
  localparam int P2_W   = WP_W + M2_W;
  localparam int WIN_W  = UNIT_W + 1;
  localparam int LONG_W = UNIT_W + $clog2(LONG_RATIO + 1);
  localparam int CMP_W  = ((LONG_W > DUR_W) ? LONG_W : DUR_W) + 2;

  ook_pwd_bstate_t       state_r, state_nxt;
  logic [P1_W-1:0]       prod1_r, prod1_nxt;
  logic [WP_W-1:0]       prod2_r, prod2_nxt;
  logic [UNIT_W-1:0]     unit_r, unit_nxt;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [LONG_W-1:0]     long_r, long_nxt;
  logic [2:0][1:0]       grp_r, grp_nxt;
  logic [CODE_BITS-1:0]  shift_r, shift_nxt;
  logic                  failed_r, failed_nxt;
  logic                  pend_last_r, pend_last_nxt;
  logic [BITS_W-1:0]     pend_bits_r, pend_bits_nxt;
  logic                  pend_stored_r, pend_stored_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ook_pwd_out_t          out_r, out_nxt;

  logic                  out_free;
  logic                  out_load;
  logic [P2_W-1:0]       win_prod;
  logic [UNIT_W-1:0]     unit_calc;
  logic [1:0]            cls;
  logic                  is_zero, is_one;
  logic [CODE_BITS-1:0]  code_val;
  logic [BITS_W-1:0]     res_bits;
  logic                  res_stored;

  function automatic logic in_rng(input logic [CMP_W-1:0] d, input logic [CMP_W-1:0] c,
                                  input logic [CMP_W-1:0] w);
    return (d + w > c) && (d < c + w);
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign unit_calc = UNIT_W'(prod1_r >> M1_SH);
  assign win_prod  = P2_W'(prod2_r) * P2_W'(M2);

  always_comb begin
    cls[CLS_SHORT] = in_rng(CMP_W'(head.entry.duration), CMP_W'(unit_r), CMP_W'(win_r));
    cls[CLS_LONG]  = in_rng(CMP_W'(head.entry.duration), CMP_W'(long_r), CMP_W'(win_r));
    is_zero = grp_r[0][CLS_SHORT] && grp_r[1][CLS_SHORT] && grp_r[2][CLS_SHORT] &&
              cls[CLS_LONG];
    is_one  = grp_r[0][CLS_SHORT] && grp_r[1][CLS_LONG] && grp_r[2][CLS_SHORT] &&
              cls[CLS_SHORT];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (head.valid && head.entry.kind == KIND_SYNC) begin
          state_nxt = BK_UNIT;
        end
      end
      BK_UNIT: begin
        state_nxt = BK_WIN;
      end
      BK_WIN: begin
        if (!pend_last_r || out_free) begin
          state_nxt = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop             = 1'b0;
    out_load        = 1'b0;
    prod1_nxt       = prod1_r;
    prod2_nxt       = prod2_r;
    unit_nxt        = unit_r;
    win_nxt         = win_r;
    long_nxt        = long_r;
    grp_nxt         = grp_r;
    shift_nxt       = shift_r;
    failed_nxt      = failed_r;
    pend_last_nxt   = pend_last_r;
    pend_bits_nxt   = pend_bits_r;
    pend_stored_nxt = pend_stored_r;
    res_bits        = head.entry.bit_count;
    res_stored      = head.entry.stored;

    case (state_r)
      BK_RUN: begin
        if (head.valid && head.entry.kind == KIND_SYNC) begin
          pop             = 1'b1;
          prod1_nxt       = P1_W'(head.entry.duration) * P1_W'(M1);
          grp_nxt         = '0;
          shift_nxt       = '0;
          failed_nxt      = 1'b0;
          pend_last_nxt   = head.entry.last;
          pend_bits_nxt   = head.entry.bit_count;
          pend_stored_nxt = head.entry.stored;
        end else if (head.valid && (!head.entry.last || out_free)) begin
          pop      = 1'b1;
          out_load = head.entry.last;
          case (head.entry.kind)
            KIND_SLOT: begin
              case (head.entry.slot)
                2'd0:    grp_nxt[0] = cls;
                2'd1:    grp_nxt[1] = cls;
                default: grp_nxt[2] = cls;
              endcase
            end
            KIND_CHECK: begin
              if (!failed_r) begin
                if (is_zero || is_one) begin
                  shift_nxt = {shift_r[CODE_BITS-2:0], !is_zero};
                end else begin
                  failed_nxt = 1'b1;
                  shift_nxt  = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_UNIT: begin
        unit_nxt  = unit_calc;
        prod2_nxt = WP_W'(unit_calc) * WP_W'(tolerance);
      end
      BK_WIN: begin
        win_nxt    = WIN_W'(win_prod >> M2_SH);
        long_nxt   = LONG_W'(unit_r) * LONG_W'(LONG_RATIO);
        res_bits   = pend_bits_r;
        res_stored = pend_stored_r;
        out_load   = pend_last_r && out_free;
      end
      default: begin
      end
    endcase

    code_val          = failed_nxt ? '0 : shift_nxt;
    out_nxt.code      = CODE_W'(code_val);
    out_nxt.bit_count = res_bits;
    out_nxt.unit_delay = UNIT_OUT_W'(unit_r);
    out_nxt.stored    = res_stored;
    out_nxt.decoded   = (CODE_W'(code_val) != '0);

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r       <= prod1_nxt;
    prod2_r       <= prod2_nxt;
    pend_bits_r   <= pend_bits_nxt;
    pend_stored_r <= pend_stored_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      unit_r      <= '0;
      win_r       <= '0;
      long_r      <= '0;
      grp_r       <= '0;
      shift_r     <= '0;
      failed_r    <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unit_r      <= unit_nxt;
      win_r       <= win_nxt;
      long_r      <= long_nxt;
      grp_r       <= grp_nxt;
      shift_r     <= shift_nxt;
      failed_r    <= failed_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/ook_pulse_width_decoder.sv]
// OOK pulse-width decoder. Each request carries one measured edge-to-edge
// duration; the sync gap opens a frame and fixes the unit delay (sync/SYNC_RATIO)
// and the tolerance window (unit * cfg_wdata percent). Groups of four durations
// from the fourth on decode to 0 (short,short,short,long) or 1 (short,long,short,short);
// one result leaves on the request marked frame_end. A front end tags each request
// with its frame position and writes it to a QUEUE_DEPTH-entry queue; the back end
// classifies and shifts one request per cycle unless a frame_end request waits for
// the output to be taken. The sync request holds the back end through the reciprocal
// multiply for the unit, then the window product; the queue takes requests at one per
// cycle meanwhile while it is not full. Each result is registered in the back end.
module ook_pulse_width_decoder #(
  parameter int CODE_BITS   = 32,
  parameter int SYNC_RATIO  = 38,
  parameter int LONG_RATIO  = 5,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ook_pwd_pkg::ook_pwd_in_t      in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ook_pwd_pkg::ook_pwd_out_t     out_data,
  input  logic                          cfg_we,
  input  logic [ook_pwd_pkg::TOL_W-1:0] cfg_wdata
);
  import ook_pwd_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic [TOL_W-1:0] tol_nxt;
  logic             q_full;
  logic             push;
  logic             pop;
  ook_pwd_entry_t   push_entry;
  ook_pwd_head_t    head;

  assign tol_nxt = cfg_we ? cfg_wdata : tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  ook_pwd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ook_pwd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head       (head),
    .pop        (pop)
  );

  ook_pwd_back #(
    .CODE_BITS  (CODE_BITS),
    .SYNC_RATIO (SYNC_RATIO),
    .LONG_RATIO (LONG_RATIO)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tolerance (tol_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_decoded_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.decoded == (out_data.code != '0)))
    else $error("decoded flag disagrees with code");

  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bit_count == '0) |-> (out_data.code == '0 && !out_data.stored))
    else $error("frame without a full group reports a code");

endmodule

[tb/sv/ook_pwd_checker.sv]
module ook_pwd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ook_pwd_pkg::ook_pwd_in_t      in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ook_pwd_pkg::ook_pwd_out_t     out_data,
  input  logic                          cfg_we,
  input  logic [ook_pwd_pkg::TOL_W-1:0] cfg_wdata,
  output int                            errors,
  output int                            outstanding
);
  import ook_pwd_pkg::*;

  localparam int SYNC_RATIO = 38;
  localparam int LONG_RATIO = 5;
  localparam int WIN_W      = UNIT_OUT_W + 1;

  logic [TOL_W-1:0]      tol_pct;
  logic [UNIT_OUT_W-1:0] unit_q;
  logic [WIN_W-1:0]      win_q;
  logic [IDX_W-1:0]      pos_q;
  logic [5:0]            group_cls_q;
  logic [CODE_W-1:0]     shift_q;
  logic                  failed_q;
  ook_pwd_out_t          frame_results_q[$];
  int                    mismatches;

  function automatic logic [1:0] classify_pulse(logic [DUR_W-1:0] d,
                                                logic [UNIT_OUT_W-1:0] u,
                                                logic [WIN_W-1:0] w);
    logic [1:0]     c;
    longint signed dv;
    longint signed sc;
    longint signed lc;
    longint signed ws;
    dv = d;
    sc = u;
    lc = sc * LONG_RATIO;
    ws = w;
    c = '0;
    if (dv > sc - ws && dv < sc + ws) c[CLS_SHORT] = 1'b1;
    if (dv > lc - ws && dv < lc + ws) c[CLS_LONG] = 1'b1;
    return c;
  endfunction

  task automatic decode_pulse(ook_pwd_in_t it);
    logic [IDX_W-1:0]  pos;
    logic [1:0]        k;
    logic [1:0]        c;
    logic [1:0]        c0;
    logic [1:0]        c1;
    logic [1:0]        c2;
    logic              bit0;
    logic              bit1;
    logic [CODE_W-1:0] code;
    ook_pwd_out_t      r;
    if (it.frame_start) pos_q = '0;
    pos = pos_q;
    if (pos == 0) begin
      unit_q      = UNIT_OUT_W'(it.duration / SYNC_RATIO);
      win_q       = WIN_W'((32'(unit_q) * 32'(tol_pct)) / PCT_DIV);
      group_cls_q = '0;
      shift_q     = '0;
      failed_q    = 1'b0;
    end else if (pos >= FIRST_POS && pos <= LAST_POS) begin
      k = 2'(pos - FIRST_POS);
      c = classify_pulse(it.duration, unit_q, win_q);
      if (k != SLOT_CHECK) begin
        group_cls_q[2*k +: 2] = c;
      end else if (!failed_q) begin
        c0   = group_cls_q[1:0];
        c1   = group_cls_q[3:2];
        c2   = group_cls_q[5:4];
        bit0 = c0[CLS_SHORT] && c1[CLS_SHORT] && c2[CLS_SHORT] && c[CLS_LONG];
        bit1 = c0[CLS_SHORT] && c1[CLS_LONG] && c2[CLS_SHORT] && c[CLS_SHORT];
        if (bit0) begin
          shift_q = {shift_q[CODE_W-2:0], 1'b0};
        end else if (bit1) begin
          shift_q = {shift_q[CODE_W-2:0], 1'b1};
        end else begin
          failed_q = 1'b1;
          shift_q  = '0;
        end
      end
    end
    if (pos_q != IDX_MAX) pos_q = pos_q + 1'b1;
    if (it.frame_end) begin
      code        = failed_q ? '0 : shift_q;
      r.code      = code;
      r.bit_count = pos_q[IDX_W-1:2];
      r.unit_delay = unit_q;
      r.stored    = pos_q > STORE_MIN;
      r.decoded   = |code;
      frame_results_q.push_back(r);
      pos_q = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    ook_pwd_out_t want;
    if (!rst_n) begin
      tol_pct     = TOL_RESET;
      unit_q      = '0;
      win_q       = '0;
      pos_q       = '0;
      group_cls_q = '0;
      shift_q     = '0;
      failed_q    = 1'b0;
      frame_results_q.delete();
    end else begin
      if (cfg_we) tol_pct = cfg_wdata;
      if (in_valid && in_ready) decode_pulse(in_data);
      if (out_valid && out_ready) begin
        if (frame_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result code=%h bits=%0d unit=%0d st=%b dec=%b",
                     out_data.code, out_data.bit_count, out_data.unit_delay,
                     out_data.stored, out_data.decoded);
        end else begin
          want = frame_results_q.pop_front();
          if (out_data.code !== want.code || out_data.bit_count !== want.bit_count ||
              out_data.unit_delay !== want.unit_delay || out_data.stored !== want.stored ||
              out_data.decoded !== want.decoded) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected code=%h bits=%0d unit=%0d st=%b dec=%b",
                       want.code, want.bit_count, want.unit_delay, want.stored,
                       want.decoded);
              $display("          actual   code=%h bits=%0d unit=%0d st=%b dec=%b",
                       out_data.code, out_data.bit_count, out_data.unit_delay,
                       out_data.stored, out_data.decoded);
            end
          end
        end
      end
    end
    errors      <= mismatches;
    outstanding <= frame_results_q.size();
  end

endmodule

[tb/sv/tb.sv]
module tb;
  import ook_pwd_pkg::*;

  localparam int CLK_HALF  = 4;
  localparam int LIMIT     = 600000;
  localparam int DRAIN     = 24;
  localparam int UNIT_MAX  = 27594;
  localparam int DUR_MAX   = 1048575;
  localparam int PHASE_LEN = 75;

  typedef enum int {FR_GOOD, FR_NOISE, FR_HUGE} frame_kind_t;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  ook_pwd_in_t      in_data   = '0;
  logic             out_ready = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic             in_ready;
  logic             out_valid;
  ook_pwd_out_t     out_data;
  int               errors;
  int               outstanding;
  int               cycles    = 0;
  int               sent      = 0;
  bit               no_idle   = 1'b0;
  logic [TOL_W-1:0] tol_now   = TOL_RESET;

  ook_pulse_width_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ook_pwd_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DUR_W-1:0] clamp_dur(longint v);
    if (v < 0) return '0;
    if (v > DUR_MAX) return '1;
    return v[DUR_W-1:0];
  endfunction

  function automatic logic [DUR_W-1:0] near(int centre, int w);
    int r;
    int off;
    r = $urandom_range(0, 99);
    if (w == 0) off = 0;
    else if (r < 3) off = w;
    else if (r < 6) off = -w;
    else if (r < 10) off = w - 1;
    else if (r < 14) off = 1 - w;
    else off = int'($urandom_range(0, 2 * w - 2)) - (w - 1);
    return clamp_dur(longint'(centre) + off);
  endfunction

  function automatic ook_pwd_in_t pulse(logic [DUR_W-1:0] d, logic s, logic e);
    ook_pwd_in_t it;
    it.duration    = d;
    it.frame_start = s;
    it.frame_end   = e;
    return it;
  endfunction

  task automatic send_pulse(ook_pwd_in_t it);
    int g;
    g = idle_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_now = v;
  endtask

  task automatic send_frame(frame_kind_t kind);
    ook_pwd_in_t fr[$];
    int          unit;
    int          w;
    int          umax;
    int          dmax;
    int          ngroups;
    int          trail;
    int          r;
    int          idx;
    logic        b;
    umax = (tol_now > PCT_DIV) ? 3276700 / tol_now : UNIT_MAX;
    dmax = (tol_now > PCT_DIV) ? umax * 38 : DUR_MAX;
    if (kind == FR_NOISE) begin
      r = $urandom_range(1, 14);
      for (int i = 0; i < r; i++)
        fr.push_back(pulse(DUR_W'($urandom_range(0, dmax)),
                           (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) == 0),
                           1'b0));
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) unit = $urandom_range(1, 200);
      else if (r < 8) unit = $urandom_range(200, 5000);
      else unit = $urandom_range(5000, umax);
      w = unit * tol_now / PCT_DIV;
      fr.push_back(pulse(clamp_dur(longint'(unit) * 38 + $urandom_range(0, 37)),
                         $urandom_range(0, 9) != 0, 1'b0));
      fr.push_back(pulse(DUR_W'($urandom_range(0, DUR_MAX)), 1'b0, 1'b0));
      fr.push_back(pulse(DUR_W'($urandom_range(0, DUR_MAX)), 1'b0, 1'b0));
      if (kind == FR_HUGE) ngroups = 64;
      else if ($urandom_range(0, 9) == 0) ngroups = $urandom_range(13, 40);
      else ngroups = $urandom_range(0, 12);
      for (int g = 0; g < ngroups; g++) begin
        b = 1'($urandom_range(0, 1));
        fr.push_back(pulse(near(unit, w), 1'b0, 1'b0));
        fr.push_back(pulse(b ? near(5 * unit, w) : near(unit, w), 1'b0, 1'b0));
        fr.push_back(pulse(near(unit, w), 1'b0, 1'b0));
        fr.push_back(pulse(b ? near(unit, w) : near(5 * unit, w), 1'b0, 1'b0));
      end
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int t = 0; t < trail; t++) fr.push_back(pulse(near(unit, w), 1'b0, 1'b0));
      r   = $urandom_range(0, 99);
      idx = $urandom_range(1, fr.size() - 1);
      if (r < 10) begin
        fr[idx].duration = DUR_W'($urandom_range(0, DUR_MAX));
      end else if (r < 15) begin
        fr[idx].frame_start = 1'b1;
        fr[idx].duration    = DUR_W'($urandom_range(0, dmax));
      end
    end
    fr[fr.size() - 1].frame_end = 1'b1;
    foreach (fr[i]) send_pulse(fr[i]);
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      int g;
      g = idle_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (no_idle ? 20 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_plan[6];
    int               target;
    tol_plan = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd0, 7'd60};
    tol_plan[4] = TOL_W'($urandom_range(0, 127));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sync-only frames at both ends of the duration range
    send_pulse(pulse('1, 1'b1, 1'b1));
    send_pulse(pulse('0, 1'b1, 1'b1));
    // unit 380, window 228: a one, a zero at the window edges, then a dangling pulse
    send_pulse(pulse(20'd14477, 1'b1, 1'b0));
    send_pulse(pulse('1, 1'b0, 1'b0));
    send_pulse(pulse('0, 1'b0, 1'b0));
    send_pulse(pulse(20'd380, 1'b0, 1'b0));
    send_pulse(pulse(20'd1900, 1'b0, 1'b0));
    send_pulse(pulse(20'd380, 1'b0, 1'b0));
    send_pulse(pulse(20'd380, 1'b0, 1'b0));
    send_pulse(pulse(20'd153, 1'b0, 1'b0));
    send_pulse(pulse(20'd607, 1'b0, 1'b0));
    send_pulse(pulse(20'd380, 1'b0, 1'b0));
    send_pulse(pulse(20'd2127, 1'b0, 1'b0));
    send_pulse(pulse(20'd380, 1'b0, 1'b1));
    // sync without the start flag
    send_pulse(pulse(20'd14440, 1'b0, 1'b0));
    send_pulse(pulse(20'd1, 1'b0, 1'b0));
    send_pulse(pulse(20'd2, 1'b0, 1'b1));
    // restart in the middle of a frame
    send_pulse(pulse(20'd3800, 1'b1, 1'b0));
    send_pulse(pulse(20'd5, 1'b0, 1'b0));
    send_pulse(pulse(20'd7600, 1'b1, 1'b0));
    send_pulse(pulse(20'd9, 1'b0, 1'b0));
    send_pulse(pulse(20'd11, 1'b0, 1'b1));

    foreach (tol_plan[p]) begin
      settle();
      set_tolerance(tol_plan[p]);
      if (p == 1) send_frame(FR_HUGE);
      target = sent + PHASE_LEN;
      while (sent < target) begin
        no_idle = ($urandom_range(0, 4) == 0);
        send_frame(($urandom_range(0, 9) < 7) ? FR_GOOD : FR_NOISE);
      end
      no_idle = 1'b0;
    end
    settle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
